/* hw/rtl/phlt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak hold level tracker package
// Shared types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package phlt_pkg;

	typedef logic signed [13:0] level_t;
	typedef logic signed [11:0] vu_t;
	typedef logic [1:0]         reg_idx_t;

	localparam reg_idx_t REG_PEAK_HOLD_EN = 2'd0;
	localparam reg_idx_t REG_HOLD_TIME    = 2'd1;
	localparam reg_idx_t REG_DECAY_RATE   = 2'd2;

	localparam level_t LEVEL_FLOOR = -14'sd6000;
	localparam level_t LEVEL_CEIL  = 14'sd0;
	localparam level_t VU_KNEE     = -14'sd1800;

	localparam logic [15:0] HOLD_TIME_RST  = 16'd1200;
	localparam logic [15:0] DECAY_RATE_RST = 16'd1800;

	// decay = min(rate * elapsed / 1000, 6000)
	localparam logic [12:0] DECAY_SAT      = 13'd6000;
	localparam logic [31:0] DECAY_SAT_PROD = 32'd6001000;
	// x / 1000 = (x >> 3) / 125, exact for x >> 3 below 2^20
	localparam logic [20:0] DIV125_M       = 21'd1073742;
	localparam int          DIV125_SH      = 27;

	// lower VU segment: (20x + 21) / 42 = ((20x + 21) >> 1) / 21
	localparam logic [16:0] DIV21_M  = 17'd99865;
	localparam int          DIV21_SH = 21;
	// upper VU segment: divide by 3
	localparam logic [11:0] DIV3_M   = 12'd2731;
	localparam int          DIV3_SH  = 13;

	localparam vu_t VU_MIN = -12'sd2000;
	localparam vu_t VU_MAX = 12'sd300;

endpackage

/* hw/rtl/peak_hold_level_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak hold level tracker
// Clamps level samples, tracks a held peak with hold countdown and decay,
// and reports both levels in dBFS and on the VU scale.
// Each word passes registers s1, s2, s3, s4, then the output register.
// Throughput: one word per cycle unless stalled; peak state: single stage.
// Decay path: 16x16 multiply, then reciprocal divide by 1000, one stage each.
// Reset: levels to -60 dB, countdown zero, not primed, registers to defaults.
// ----------------------------------------------------------------------------
module peak_hold_level_tracker
	import phlt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] level_cdb,
	input  logic [15:0]        elapsed_ms,

	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [13:0] level_out_cdb,
	output logic signed [13:0] peak_out_cdb,
	output logic signed [11:0] level_vu,
	output logic signed [11:0] peak_vu,
	output logic               peak_shown,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  reg_idx_t           cfg_index,
	input  logic [15:0]        cfg_data
);

	logic        adv;
	logic        v_s1, v_s2, v_s3, v_s4;

	logic        en_q;
	logic [15:0] hold_time_q;
	logic [15:0] rate_q;

	level_t      cur_q, peak_q;
	logic [15:0] hold_q;
	logic        primed_q;

	level_t      lvl_in;
	level_t      lvl_s1, lvl_s2, lvl_s3, lvl_s4;
	logic [15:0] el_s1, el_s2, el_s3;
	logic [31:0] prod_s2;
	logic [12:0] decay_s3;
	level_t      peak_s4;
	logic        shown_s4;

	logic [40:0] div_mul;
	logic [12:0] div_q;

	level_t      peak_nxt;
	logic [15:0] hold_nxt;
	logic        primed_nxt;
	logic signed [14:0] np;

	vu_t         level_vu_c, peak_vu_c;
	logic        cfg_we;

	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_comb begin
		if (level_cdb < 16'(LEVEL_FLOOR)) begin
			lvl_in = LEVEL_FLOOR;
		end else if (level_cdb > 16'(LEVEL_CEIL)) begin
			lvl_in = LEVEL_CEIL;
		end else begin
			lvl_in = level_cdb[13:0];
		end
	end

	always_comb begin
		div_mul = {21'b0, prod_s2[22:3]} * {20'b0, DIV125_M};
		div_q   = div_mul[DIV125_SH +: 13];
	end

	// peak state update
	always_comb begin
		peak_nxt   = peak_q;
		hold_nxt   = hold_q;
		primed_nxt = primed_q;
		np         = 15'(peak_q) - 15'(signed'({1'b0, decay_s3}));
		if (en_q) begin
			if (!primed_q) begin
				primed_nxt = 1'b1;
				peak_nxt   = lvl_s3;
			end else if (lvl_s3 >= peak_q) begin
				peak_nxt = lvl_s3;
				hold_nxt = hold_time_q;
			end else if (hold_q != 16'd0) begin
				hold_nxt = (hold_q > el_s3) ? hold_q - el_s3 : 16'd0;
			end else if (np < 15'(lvl_s3)) begin
				peak_nxt = lvl_s3;
			end else begin
				peak_nxt = np[13:0];
			end
		end
	end

	phlt_vu u_level_vu (
		.d  (lvl_s4),
		.vu (level_vu_c)
	);

	phlt_vu u_peak_vu (
		.d  (peak_s4),
		.vu (peak_vu_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lvl_s1        <= lvl_in;
			el_s1         <= elapsed_ms;
			lvl_s2        <= lvl_s1;
			el_s2         <= el_s1;
			prod_s2       <= {16'b0, el_s1} * {16'b0, rate_q};
			lvl_s3        <= lvl_s2;
			el_s3         <= el_s2;
			decay_s3      <= (prod_s2 >= DECAY_SAT_PROD) ? DECAY_SAT : div_q;
			lvl_s4        <= lvl_s3;
			peak_s4       <= peak_nxt;
			shown_s4      <= en_q && primed_nxt;
			level_out_cdb <= lvl_s4;
			peak_out_cdb  <= peak_s4;
			level_vu      <= level_vu_c;
			peak_vu       <= peak_vu_c;
			peak_shown    <= shown_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q        <= 1'b0;
			hold_time_q <= HOLD_TIME_RST;
			rate_q      <= DECAY_RATE_RST;
			cur_q       <= LEVEL_FLOOR;
			peak_q      <= LEVEL_FLOOR;
			hold_q      <= 16'd0;
			primed_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PEAK_HOLD_EN: begin
					if (cfg_data[0] != en_q) begin
						en_q     <= cfg_data[0];
						peak_q   <= cur_q;
						hold_q   <= 16'd0;
						primed_q <= 1'b1;
					end
				end
				REG_HOLD_TIME: begin
					hold_time_q <= cfg_data;
				end
				REG_DECAY_RATE: begin
					rate_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end else if (adv && v_s3) begin
			cur_q    <= lvl_s3;
			peak_q   <= peak_nxt;
			hold_q   <= hold_nxt;
			primed_q <= primed_nxt;
		end
	end

`ifndef SYNTHESIS
	a_peak_range: assert property (@(posedge clk) disable iff (!arst_n)
		(peak_q >= LEVEL_FLOOR) && (peak_q <= LEVEL_CEIL))
		else $error("peak left the -60..0 dB range");

	a_hold_needs_en: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_q != 16'd0) |-> (en_q && primed_q))
		else $error("hold countdown running while peak hold is off");

	a_primed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		primed_q |=> primed_q)
		else $error("primed flag cleared");

	a_decay_sat: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (decay_s3 <= DECAY_SAT))
		else $error("decay step above saturation");

	a_peak_above_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && peak_shown) |-> (peak_out_cdb >= level_out_cdb))
		else $error("shown peak below current level");
`endif

endmodule

/* hw/rtl/phlt_vu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dBFS to VU conversion
// Two linear segments, rounded to nearest, halves upward, clamped to +3 VU.
// ----------------------------------------------------------------------------
module phlt_vu
	import phlt_pkg::*;
(
	input  level_t d,
	output vu_t    vu
);

	logic [12:0] x;
	logic [16:0] y;
	logic [32:0] lo_mul;
	logic [10:0] lo_q;
	logic signed [14:0] z_full;
	logic [10:0] z;
	logic [22:0] hi_mul;
	logic [9:0]  hi_q;

	always_comb begin
		x      = 13'(d - LEVEL_FLOOR);
		y      = 17'(({4'b0, x} * 17'd20) + 17'd21);
		lo_mul = {17'b0, y[16:1]} * {16'b0, DIV21_M};
		lo_q   = lo_mul[DIV21_SH +: 11];

		z_full = 15'(d) + 15'sd1801;
		z      = z_full[10:0];
		hi_mul = {12'b0, z} * {11'b0, DIV3_M};
		hi_q   = hi_mul[DIV3_SH +: 10];

		if (d <= VU_KNEE) begin
			vu = VU_MIN + vu_t'({1'b0, lo_q});
		end else if (hi_q > 10'(VU_MAX)) begin
			vu = VU_MAX;
		end else begin
			vu = vu_t'({2'b0, hi_q});
		end
	end

endmodule
